// File: design/ffsa_pkg.sv
// Shared widths, codes and helpers for the first-fit slot allocator.
package ffsa_pkg;

  localparam int SLOTS  = 1024;
  localparam int CNT_W  = 11;
  localparam int SLOT_W = 10;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int TGT_W  = CNT_W - BIT_W;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_SLOT_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Edit applied to the map word as it leaves the head of the ring.
  typedef struct packed {
    logic [WORD_W-1:0] set_mask;
    logic [WORD_W-1:0] clr_mask;
  } ffsa_mod_t;

  // Lowest set bit of a map word; the top bit of the result says one was found.
  function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, BIT_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

// File: design/ffsa_cell.sv
// One cell of the used-map ring: a 32-slot word taken from its neighbor every cycle.
module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] word_in,
  output logic [WORD_W-1:0] word_out
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

// File: design/ffsa_ring.sv
// Rotating ring of used-map cells with a counter tracking which word sits at the head.
module ffsa_ring
  import ffsa_pkg::*;
#(
  parameter int NW = 32,
  parameter int HW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffsa_mod_t         edit,
  output logic [WORD_W-1:0] head_word,
  output logic [HW-1:0]     head_idx
);

  logic [WORD_W-1:0] q [NW];
  logic [WORD_W-1:0] wrap_word;
  logic [HW-1:0]     head_r;
  logic [HW-1:0]     head_nxt;

  // The head word is edited on its way round to the tail.
  assign wrap_word = (q[0] & ~edit.clr_mask) | edit.set_mask;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    logic [WORD_W-1:0] d;
    if (k == NW - 1) begin : g_tail
      assign d = wrap_word;
    end else begin : g_mid
      assign d = q[k+1];
    end
    ffsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .word_in  (d),
      .word_out (q[k])
    );
  end

  assign head_nxt = (head_r == HW'(NW - 1)) ? '0 : head_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign head_word = q[0];
  assign head_idx  = head_r;

endmodule

// File: design/first_fit_slot_allocator.sv
// First-fit slot allocator: used map in a rotating ring of word cells, with hint and high-water.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------------
//  in_     | slave     | tvalid/tready      | tdata: free_slot; tuser: command
//  out_    | master    | tvalid/tready      | tdata: given_slot, high_water; tuser: status
//  cfg_    | APB slave | psel/penable/ready | register 0 at address 0: slot_count
//
// An allocate or an in-range free passes from its input beat through S_CHECK and S_SEEK, where it
// waits for its map word to rotate to the head of the ring and, on allocate, scans each further
// word as it reaches the head, then through S_DONE into the output register; its wait is set by
// the single read point at the ring head.
// Out-of-range frees and allocates with the hint at or above the count skip S_SEEK.
// Reset clears every used bit, the hint and the high-water mark at once; no sweep is needed.
// A new request is taken while a result still waits on a stalled output.
module first_fit_slot_allocator
  import ffsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] free_slot, [15:10] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] given_slot, [20:10] high_water, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int HW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [31:0] SLOTS_U = 32'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SEEK, S_DONE} state_t;

  state_t            state_r;
  logic              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [CNT_W-1:0]  hint_r;
  logic [CNT_W-1:0]  hw_r;
  logic [CNT_W-1:0]  count_r;
  logic [SLOT_W-1:0] res_given_r;
  status_t           res_status_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_given_r;
  logic [CNT_W-1:0]  out_hw_r;
  status_t           out_status_r;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_m1;
  logic [TGT_W-1:0]  last_w;
  logic [CNT_W-1:0]  slot_ext;
  logic [WORD_W-1:0] head_word;
  logic [HW-1:0]     head_idx;
  logic              aligned;
  logic [WORD_W-1:0] ones;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] cand;
  logic [BIT_W:0]    pick;
  logic              found;
  logic [CNT_W-1:0]  found_slot;
  logic [CNT_W-1:0]  found_inc;
  ffsa_mod_t         edit;
  logic              cfg_wr;

  assign n_eff    = ({21'd0, count_r} > SLOTS_U) ? CNT_W'(SLOTS) : count_r;
  assign n_m1     = n_eff - 1'b1;
  assign last_w   = n_m1[CNT_W-1:BIT_W];
  assign slot_ext = {1'b0, slot_r};
  assign aligned  = (head_idx == HW'(tgt_r));

  // Only slots at or above the hint and below the count are candidates.
  assign ones    = '1;
  assign lo_mask = (tgt_r == hint_r[CNT_W-1:BIT_W]) ? (ones << hint_r[BIT_W-1:0]) : ones;
  assign hi_mask = (tgt_r == n_eff[CNT_W-1:BIT_W]) ? ~(ones << n_eff[BIT_W-1:0]) : ones;
  assign cand    = ~head_word & lo_mask & hi_mask;
  assign pick    = first_set(cand);
  assign found   = pick[BIT_W];
  assign found_slot = {tgt_r, pick[BIT_W-1:0]};
  assign found_inc  = found_slot + 1'b1;

  always_comb begin
    edit = '0;
    if (state_r == S_SEEK && aligned) begin
      if (cmd_r == CMD_FREE) begin
        edit.clr_mask = WORD_W'(1) << slot_r[BIT_W-1:0];
      end else if (found) begin
        edit.set_mask = WORD_W'(1) << pick[BIT_W-1:0];
      end
    end
  end

  ffsa_ring #(
    .NW (NW),
    .HW (HW)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .edit      (edit),
    .head_word (head_word),
    .head_idx  (head_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hint_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            slot_r  <= in_tdata[SLOT_W-1:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_given_r <= '0;
          if (cmd_r == CMD_ALLOC) begin
            if (hint_r >= n_eff) begin
              res_status_r <= ST_OOM;
              state_r      <= S_DONE;
            end else begin
              tgt_r   <= hint_r[CNT_W-1:BIT_W];
              state_r <= S_SEEK;
            end
          end else begin
            if (slot_ext >= n_eff) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_DONE;
            end else begin
              tgt_r   <= slot_ext[CNT_W-1:BIT_W];
              state_r <= S_SEEK;
            end
          end
        end
        S_SEEK: begin
          if (aligned) begin
            if (cmd_r == CMD_FREE) begin
              if (slot_ext < hint_r) begin
                hint_r <= slot_ext;
              end
              res_status_r <= ST_OK;
              state_r      <= S_DONE;
            end else if (found) begin
              hint_r <= found_inc;
              if (found_inc > hw_r) begin
                hw_r <= found_inc;
              end
              res_given_r  <= found_slot[SLOT_W-1:0];
              res_status_r <= ST_OK;
              state_r      <= S_DONE;
            end else if (tgt_r == last_w) begin
              res_status_r <= ST_OOM;
              state_r      <= S_DONE;
            end else begin
              tgt_r <= tgt_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_given_r  <= res_given_r;
            out_status_r <= res_status_r;
            out_hw_r     <= hw_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == CFG_SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_wr) begin
      count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_SLOT_COUNT) ? {21'd0, count_r} : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_hw_r, out_given_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // A failed request never reports a slot.
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_given_r == '0))
    else $error("failed request reports a nonzero slot");

  // The high-water mark only rises.
  a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n ##1 rst_n) |-> (hw_r >= $past(hw_r)))
    else $error("high-water mark decreased");

  // An allocate scan never walks past the last word below the count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEEK && cmd_r == CMD_ALLOC) |-> (tgt_r <= last_w))
    else $error("allocate scan beyond slot count");

  // A successful allocate leaves the hint just past the slot it gave.
  a_hint_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEEK && cmd_r == CMD_ALLOC && aligned && found)
      |=> (hint_r == $past(found_inc)))
    else $error("hint not moved past allocated slot");
`endif

endmodule

// File: bench/tb_first_fit_slot_allocator.sv
// Testbench for the first-fit slot allocator: streamed requests checked against a slot pool model.
module tb_first_fit_slot_allocator import ffsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 600000;
  // Extra wait after the last reply, sized from the number of ring words with some margin.
  localparam int SETTLE = 2 * ((SLOTS + WORD_W - 1) / WORD_W) + 16;

  typedef struct {
    logic [SLOT_W-1:0] given;
    status_t           status;
    logic [CNT_W-1:0]  high_water;
  } reply_t;

  class slot_pool_model;
    bit [SLOTS-1:0]   slot_used;
    logic [CNT_W-1:0] hint = '0;
    logic [CNT_W-1:0] peak = '0;
    logic [CNT_W-1:0] slot_count = COUNT_RESET;
    reply_t           replies_due[$];
    int               errors = 0;

    function int pending();
      return replies_due.size();
    endfunction

    function void take_request(logic cmd, logic [SLOT_W-1:0] slot);
      int unsigned n;
      int unsigned i;
      reply_t r;
      n = (slot_count > SLOTS) ? SLOTS : slot_count;
      r.given = '0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
        i = hint;
        while (i < n && slot_used[i]) i++;
        if (i < n) begin
          slot_used[i] = 1'b1;
          hint = CNT_W'(i + 1);
          if (i + 1 > peak) peak = CNT_W'(i + 1);
          r.given = SLOT_W'(i);
        end else begin
          r.status = ST_OOM;
        end
      end else if (slot >= n) begin
        r.status = ST_RANGE;
      end else begin
        // Freeing a slot that is already free still pulls the hint down.
        slot_used[slot] = 1'b0;
        if (slot < hint) hint = CNT_W'(slot);
      end
      r.high_water = peak;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [SLOT_W-1:0] given, logic [1:0] status,
                              logic [CNT_W-1:0] hw);
      reply_t e;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply with no request outstanding: slot %0d status %0d high water %0d",
                 $time, given, status, hw);
        return;
      end
      e = replies_due.pop_front();
      if (given !== e.given) begin
        errors++;
        $display("%0t: given_slot expected %0d, got %0d", $time, e.given, given);
      end
      if (status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, e.status, status);
      end
      if (hw !== e.high_water) begin
        errors++;
        $display("%0t: high_water expected %0d, got %0d", $time, e.high_water, hw);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [9:0] free_slot, [15:10] zero
  logic        in_tuser;    // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [9:0] given_slot, [20:10] high_water, [23:21] zero
  logic [1:0]  out_tuser;   // [1:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  slot_pool_model pool = new;
  int unsigned    in_max_gap = 9;
  int unsigned    out_max_stall = 9;
  int unsigned    beats_sent = 0;
  int unsigned    cycles = 0;

  first_fit_slot_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_first_fit_slot_allocator failed");
      $finish;
    end
  end

  // Handshakes are sampled at the falling edge, where everything has settled
  // for the rising edge that follows.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      pool.check_reply(out_tdata[SLOT_W-1:0], out_tuser, out_tdata[SLOT_W +: CNT_W]);
  end

  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_req(input logic cmd, input logic [SLOT_W-1:0] slot);
    int unsigned gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(slot);
    in_tuser  <= cmd;
    do @(negedge clk); while (!in_tready);
    pool.take_request(cmd, slot);
    beats_sent++;
    @(posedge clk);
  endtask

  task automatic random_req(input int unsigned n, input bit fill);
    logic cmd;
    logic [SLOT_W-1:0] slot;
    // Switch between busy and bursty traffic now and then on both sides.
    if (beats_sent % 64 == 0) begin
      in_max_gap    = ($urandom_range(0, 2) == 0) ? 0 : 9;
      out_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 9;
    end
    if (fill)
      cmd = ($urandom_range(0, 63) == 0) ? CMD_FREE : CMD_ALLOC;
    else
      cmd = ($urandom_range(0, 1) == 1) ? CMD_FREE : CMD_ALLOC;
    if (n > 0 && !fill && $urandom_range(0, 3) != 0)
      slot = SLOT_W'($urandom_range(0, n - 1));
    else
      slot = SLOT_W'($urandom_range(0, 2**SLOT_W - 1));
    send_req(cmd, slot);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pool.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {CFG_SLOT_COUNT, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_count();
    logic [31:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd !== {21'b0, pool.slot_count}) begin
      pool.errors++;
      $display("%0t: slot_count read expected %0d, got %0d", $time, pool.slot_count, rd);
    end
  endtask

  // Only bits [10:0] hold the register; the rest of the write data is junk.
  task automatic program_count(input int unsigned count);
    logic [31:0] rd;
    settle();
    reg_access(1'b1, {21'($urandom), CNT_W'(count)}, rd);
    pool.slot_count = CNT_W'(count);
    check_count();
  endtask

  initial begin
    int unsigned phase_counts[7];
    phase_counts = '{1, 2, 31, 32, 33, 64, 100};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_count();

    // Full pool after reset: frees of free slots, first-fit refill below the hint.
    send_req(CMD_FREE, 10'd1023);
    send_req(CMD_ALLOC, 10'h3FF);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd1);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd0);
    send_req(CMD_FREE, 10'd0);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd5);

    // Tiny pool: hint reaching the count, no free slot above the hint, range errors.
    program_count(4);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd4);
    send_req(CMD_FREE, 10'd1023);
    send_req(CMD_FREE, 10'd2);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_ALLOC, 10'd0);

    program_count(0);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd0);

    // Saturates to the pool size.
    program_count(2047);
    send_req(CMD_FREE, 10'd1023);
    send_req(CMD_ALLOC, 10'd0);

    // Count dropped below both the hint and the high-water mark.
    program_count(2);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE, 10'd1);
    send_req(CMD_ALLOC, 10'd0);

    foreach (phase_counts[p]) begin
      program_count(phase_counts[p]);
      repeat (30) random_req(phase_counts[p], 1'b0);
    end

    // Mostly allocations over the whole pool, filling most of it.
    program_count(($urandom_range(0, 1) == 1) ? 2047 : SLOTS);
    for (int k = 0; k < 816; k++) begin
      if (k == 408) settle();
      random_req(SLOTS, 1'b1);
    end

    settle();
    if (pool.errors == 0 && pool.pending() == 0) begin
      $display("tb_first_fit_slot_allocator passed");
    end else begin
      $display("tb_first_fit_slot_allocator failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/ffsa_pkg.sv
design/ffsa_cell.sv
design/ffsa_ring.sv
design/first_fit_slot_allocator.sv
bench/tb_first_fit_slot_allocator.sv
